// ===== design/key_owner_hash_table_assert.svh =====
// Assertion macros for the key owner hash table checks.
`ifndef KEY_OWNER_HASH_TABLE_ASSERT_SVH
`define KEY_OWNER_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define KOHT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("koht check failed");

// Next-cycle implication, clocked on i_clk, off while in reset.
`define KOHT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("koht check failed");

`endif

// ===== design/koht_pkg.sv =====
// Shared types and constants of the key owner hash table.
package koht_pkg;

    // Bucket count must be a power of two (bucket is the low key bits).
    localparam int NUM_BUCKETS = 1024;
    localparam int WAYS        = 4;
    localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Queue depths, two or more.
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic {
        OP_SET    = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        logic        func;
        logic [31:0] key;
        logic [15:0] rank_in;
        logic [7:0]  vpid_in;
        logic [31:0] size_in;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic        full_res;
        logic [15:0] rank_out;
        logic [7:0]  vpid_out;
        logic [31:0] size_out;
    } t_out_item;

    // Classified command handed from front to back.
    typedef struct packed {
        t_op                 op;
        logic [BUCKET_W-1:0] bucket;
        logic [31:0]         key;
        logic [15:0]         rank;
        logic [7:0]          vpid;
        logic [31:0]         size;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_link;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_link;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [15:0] rank;
        logic [7:0]  vpid;
        logic [31:0] size;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_back_state;

endpackage

// ===== design/koht_front.sv =====
// Front end: accepts items, classifies them and queues commands for the back end.
module koht_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  koht_pkg::t_in_item     i_item,
    output logic                   o_full,
    input  koht_pkg::t_back_link   i_back,
    output koht_pkg::t_cmd_link    o_cmd
);
    import koht_pkg::*;

    t_cmd                 r_q [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count, n_count;
    logic                 accept;
    t_cmd                 cmd_new;

    assign o_full = (r_count == CMD_CNT_W'(CMD_DEPTH)) | i_back.clearing;
    assign accept = i_push & ~o_full;

    always_comb begin
        cmd_new.op     = t_op'(i_item.func);
        cmd_new.bucket = i_item.key[BUCKET_W-1:0];
        cmd_new.key    = i_item.key;
        cmd_new.rank   = i_item.rank_in;
        cmd_new.vpid   = i_item.vpid_in;
        cmd_new.size   = i_item.size_in;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (accept) begin
            n_wr_ptr = (r_wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_back.pop) begin
            n_rd_ptr = (r_rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({accept, i_back.pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= cmd_new;
        end
    end

    assign o_cmd.valid = (r_count != '0);
    assign o_cmd.cmd   = r_q[r_rd_ptr];

endmodule

// ===== design/koht_back.sv =====
// Back end: bucket RAM, clearing pass, compare and write-back, result queue.
module koht_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  koht_pkg::t_cmd_link  i_cmd,
    output koht_pkg::t_back_link o_back,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_pop,
    output logic                 o_empty,
    output koht_pkg::t_out_item  o_item
);
    import koht_pkg::*;

    t_back_state          r_state, n_state;
    logic [BUCKET_W-1:0]  r_clr_addr;
    logic [15:0]          r_node_count;
    t_cmd                 r_cmd;
    t_row                 mem [NUM_BUCKETS];
    t_row                 r_rd_row;

    t_out_item            r_rq [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_rwr_ptr, n_rwr_ptr;
    logic [RES_PTR_W-1:0] r_rrd_ptr, n_rrd_ptr;
    logic [RES_CNT_W-1:0] r_rcount, n_rcount;

    logic                 res_full;
    logic                 res_pop;
    logic                 clr_last;

    // FSM outputs
    logic                 rd_en;
    logic                 cmd_pop;
    logic                 we;
    logic [BUCKET_W-1:0]  waddr;
    t_row                 wdata;
    logic                 res_push;
    logic                 clearing;

    // compare results
    logic [WAYS-1:0]      hit_vec;
    logic [WAYS-1:0]      free_vec;
    logic [WAY_W-1:0]     hit_idx;
    logic [WAY_W-1:0]     free_idx;
    logic [WAY_W-1:0]     sel_idx;
    logic                 hit;
    logic                 free_any;
    t_row                 new_row;
    t_out_item            res_new;

    assign res_full = (r_rcount == RES_CNT_W'(RES_DEPTH));
    assign o_empty  = (r_rcount == '0);
    assign res_pop  = i_pop & ~o_empty;
    assign clr_last = (r_clr_addr == BUCKET_W'(NUM_BUCKETS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (i_cmd.valid && !res_full) n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // lowest matching way and lowest free way
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w]  = r_rd_row[w].valid && (r_rd_row[w].key == r_cmd.key);
            free_vec[w] = !r_rd_row[w].valid;
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = WAY_W'(w);
            end
            if (free_vec[w]) begin
                free_idx = WAY_W'(w);
            end
        end
        hit      = |hit_vec;
        free_any = |free_vec;
        sel_idx  = hit ? hit_idx : free_idx;

        new_row                = r_rd_row;
        new_row[sel_idx].valid = 1'b1;
        new_row[sel_idx].key   = r_cmd.key;
        new_row[sel_idx].rank  = r_cmd.rank;
        new_row[sel_idx].vpid  = r_cmd.vpid;
        new_row[sel_idx].size  = r_cmd.size;

        res_new.hit      = hit;
        res_new.full_res = (r_cmd.op == OP_SET) && !hit && !free_any;
        res_new.rank_out = '0;
        res_new.vpid_out = '0;
        res_new.size_out = '0;
        if (r_cmd.op == OP_LOOKUP) begin
            if (hit) begin
                res_new.rank_out = r_rd_row[hit_idx].rank;
                res_new.vpid_out = r_rd_row[hit_idx].vpid;
                res_new.size_out = r_rd_row[hit_idx].size;
            end else begin
                res_new.rank_out = r_node_count;
            end
        end
    end

    // FSM outputs
    always_comb begin
        rd_en    = 1'b0;
        cmd_pop  = 1'b0;
        we       = 1'b0;
        waddr    = r_cmd.bucket;
        wdata    = new_row;
        res_push = 1'b0;
        clearing = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clearing = 1'b1;
                we       = 1'b1;
                waddr    = r_clr_addr;
                wdata    = '0;
            end
            ST_IDLE: begin
                if (i_cmd.valid && !res_full) begin
                    rd_en   = 1'b1;
                    cmd_pop = 1'b1;
                end
            end
            ST_EXEC: begin
                res_push = 1'b1;
                we       = (r_cmd.op == OP_SET) && (hit || free_any);
            end
            default: begin
                clearing = 1'b1;
            end
        endcase
    end

    assign o_back.pop      = cmd_pop;
    assign o_back.clearing = clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_node_count <= 16'd1;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
    end

    // bucket RAM: one read, one write port, registered read data
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_row <= mem[i_cmd.cmd.bucket];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_pop) begin
            r_cmd <= i_cmd.cmd;
        end
    end

    // result queue
    always_comb begin
        n_rwr_ptr = r_rwr_ptr;
        n_rrd_ptr = r_rrd_ptr;
        if (res_push) begin
            n_rwr_ptr = (r_rwr_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_rwr_ptr + 1'b1;
        end
        if (res_pop) begin
            n_rrd_ptr = (r_rrd_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_rrd_ptr + 1'b1;
        end
        case ({res_push, res_pop})
            2'b10:   n_rcount = r_rcount + 1'b1;
            2'b01:   n_rcount = r_rcount - 1'b1;
            default: n_rcount = r_rcount;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwr_ptr <= '0;
            r_rrd_ptr <= '0;
            r_rcount  <= '0;
        end else begin
            r_rwr_ptr <= n_rwr_ptr;
            r_rrd_ptr <= n_rrd_ptr;
            r_rcount  <= n_rcount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_rq[r_rwr_ptr] <= res_new;
        end
    end

    assign o_item = r_rq[r_rrd_ptr];

endmodule

// ===== design/key_owner_hash_table.sv =====
// Top level of the key owner hash table: front end, back end and their wiring.
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   -------------------------------
//  item in   in         push / full             i_item (func, key, rank/vpid/size)
//  result    out        pop / empty             o_item (hit, full_res, rank/vpid/size)
//  config    in         i_cfg_we, no wait       i_cfg_wdata (node_count)
//
//  In the back end each item first has its whole bucket row read from the bucket
//  RAM, then all ways are compared and the row is written back.
//  After reset a clearing pass writes all NUM_BUCKETS (1024) bucket rows with
//  full held high; config writes are taken meanwhile.
//  A 2-deep command queue parts the front from the back, and a 2-deep result
//  queue lets items keep coming in while a result waits for pop.
module key_owner_hash_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item in
    input  logic                push,
    output logic                full,
    input  koht_pkg::t_in_item  i_item,
    // result out
    output logic                empty,
    input  logic                pop,
    output koht_pkg::t_out_item o_item,
    // config: node_count
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);
    import koht_pkg::*;

    t_cmd_link  cmd_link;   // head of command queue towards the back end
    t_back_link back_link;  // pop and clearing status back to the front

    // Front: takes an item, works out the bucket and the operation, queues it.
    koht_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_back  (back_link),
        .o_cmd   (cmd_link)
    );

    // Back: clears the table after reset, then runs each command against its
    // bucket row and queues exactly one result per item.
    koht_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_link),
        .o_back      (back_link),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_item)
    );

endmodule

// ===== design/koht_checker.sv =====
// Port-level checks of the key owner hash table and their bind.
`include "key_owner_hash_table_assert.svh"

module koht_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input koht_pkg::t_out_item o_item
);
    import koht_pkg::*;

    localparam int MAX_INFLIGHT = CMD_DEPTH + RES_DEPTH + 1;
    localparam int CNT_W        = $clog2(MAX_INFLIGHT + 2);

    logic [CNT_W-1:0] r_cnt;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = push & ~full;
    assign out_acc = pop & ~empty;

    // items taken in whose results are not yet popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // no result without an item behind it
    `KOHT_ASSERT_IMP(a_no_invented, !empty, r_cnt != '0)
    // queues plus the one in flight bound what full lets in
    `KOHT_ASSERT_IMP(a_inflight_bound, in_acc, r_cnt < CNT_W'(MAX_INFLIGHT))
    // an item into an idle block passes the command queue, the bucket read and the compare before its result is queued
    `KOHT_ASSERT_NXT(a_min_latency, in_acc && (r_cnt == '0), empty)
    // a waiting result holds until popped
    `KOHT_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(o_item))

endmodule

bind key_owner_hash_table koht_checker u_koht_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);
